// File: sv/sm4_cbc_pkcs7_codec_unit_assert.svh
// assertion macros for the sm4 cbc codec
`ifndef SM4_CBC_PKCS7_CODEC_UNIT_ASSERT_SVH
`define SM4_CBC_PKCS7_CODEC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SCC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SCC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SCC_ASSERT_IMP(label, clk, rst, ante, cons)
`define SCC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/scc_pkg.sv
package scc_pkg;

   localparam int RkDepth = 32;
   localparam int RkAddrW = 5;
   localparam int AddrW = 6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       pad_error;
   } rsp_type;

   // register byte addresses
   localparam logic [AddrW-1:0] ADDR_KEY_HIGH = 6'h00;
   localparam logic [AddrW-1:0] ADDR_KEY_LOW  = 6'h08;
   localparam logic [AddrW-1:0] ADDR_IV_HIGH  = 6'h10;
   localparam logic [AddrW-1:0] ADDR_IV_LOW   = 6'h18;
   localparam logic [AddrW-1:0] ADDR_DECRYPT  = 6'h20;

   localparam logic [31:0] FK0 = 32'ha3b1bac6;
   localparam logic [31:0] FK1 = 32'h56aa3350;
   localparam logic [31:0] FK2 = 32'h677d9197;
   localparam logic [31:0] FK3 = 32'hb27022dc;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48};
      return t[x];
   endfunction

   function automatic logic [31:0] tau(input logic [31:0] x);
      return {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
   endfunction

   // key schedule linear transform
   function automatic logic [31:0] lin_key(input logic [31:0] b);
      return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
   endfunction

   // data round linear transform
   function automatic logic [31:0] lin_data(input logic [31:0] b);
      return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
         ^ {b[7:0], b[31:8]};
   endfunction

   // round constant for key round i
   function automatic logic [31:0] ck(input logic [RkAddrW-1:0] i);
      logic [7:0] base;
      base = 8'({i, 2'b00}) * 8'd7;
      return {base, 8'(base + 8'd7), 8'(base + 8'd14), 8'(base + 8'd21)};
   endfunction

endpackage

// File: sv/scc_ram.sv
module scc_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: sv/sm4_cbc_pkcs7_codec_unit.sv
// sm4 cbc codec with pkcs7 padding, one message byte per input beat
// a byte that leaves its block partial is only stored; a completed block runs the rounds in S_CIPH
//   and a finish step in S_FIN, then gives up to 16 output beats (fewer on a final decrypt block,
//   whose pad bytes are stripped); a full final encrypt block runs a second padding block the same way
// first_byte holds the beat while key expansion runs; no byte is taken until a block's beats are out
// synchronous active-high reset clears all registers and expands the zero key
`include "sm4_cbc_pkcs7_codec_unit_assert.svh"
module sm4_cbc_pkcs7_codec_unit #(
   parameter int RkDepth = scc_pkg::RkDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  scc_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output scc_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [scc_pkg::AddrW-1:0]  paddr,
   input  logic [63:0]                pwdata,
   output logic [63:0]                prdata,
   output logic                       pready
);

   localparam int RkW = $clog2(RkDepth);

   typedef enum logic [2:0] {
      S_IDLE, S_KEXP, S_CIPH, S_FIN, S_OUT
   } state_type;

   state_type       state_ff;
   logic [63:0]     key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic            decrypt_ff;
   logic [127:0]    chain_ff, block_ff, x_ff, res_ff;
   logic [3:0]      count_ff;
   logic [RkW:0]    rnd_ff;
   logic            last_ff, full_ff, pend_pad_ff, primed_ff, rsp_valid_ff;
   logic [4:0]      emit_n_ff, emit_i_ff;
   logic            err_ff, olast_ff;
   logic            rk_we;
   logic [RkW-1:0]  rk_waddr, rk_raddr;
   logic [31:0]     rk_wdata, rk_rdata;

   assign pready = 1'b1;
   // a start beat waits until the key expansion for its message has run
   assign req_ready = (state_ff == S_IDLE) && !(req_data.first_byte && !primed_ff);
   assign rsp_valid = rsp_valid_ff;

   scc_ram #(.Width(32), .Depth(RkDepth)) u_rk (
      .clock  (clock),
      .wr_en  (rk_we),
      .wr_addr(rk_waddr),
      .wr_data(rk_wdata),
      .rd_addr(rk_raddr),
      .rd_data(rk_rdata)
   );

   // csr read mux
   always_comb begin
      case (paddr)
         scc_pkg::ADDR_KEY_HIGH: prdata = key_high_ff;
         scc_pkg::ADDR_KEY_LOW:  prdata = key_low_ff;
         scc_pkg::ADDR_IV_HIGH:  prdata = iv_high_ff;
         scc_pkg::ADDR_IV_LOW:   prdata = iv_low_ff;
         scc_pkg::ADDR_DECRYPT:  prdata = {63'd0, decrypt_ff};
         default:                prdata = 64'd0;
      endcase
   end

   // key expansion round: x_ff holds k0..k3
   logic [31:0] kround;
   assign kround = x_ff[127:96] ^ scc_pkg::lin_key(scc_pkg::tau(
      x_ff[95:64] ^ x_ff[63:32] ^ x_ff[31:0] ^ scc_pkg::ck(rnd_ff[RkW-1:0])));
   assign rk_we    = (state_ff == S_KEXP);
   assign rk_waddr = rnd_ff[RkW-1:0];
   assign rk_wdata = kround;

   // round key read, addressed for the next round so its registered word is ready when that round runs
   logic [RkW:0] rd_rnd;
   always_comb begin
      rd_rnd = (state_ff == S_CIPH) ? rnd_ff + (RkW+1)'(1) : '0;
      rk_raddr = decrypt_ff ? ~rd_rnd[RkW-1:0] : rd_rnd[RkW-1:0];
   end

   // data round on x_ff with the registered key word
   logic [31:0] dround;
   assign dround = x_ff[127:96] ^ scc_pkg::lin_data(scc_pkg::tau(
      x_ff[95:64] ^ x_ff[63:32] ^ x_ff[31:0] ^ rk_rdata));

   logic [127:0] cipher_out;
   assign cipher_out = {x_ff[31:0], x_ff[63:32], x_ff[95:64], x_ff[127:96]};

   // input beat bookkeeping
   logic [127:0] blk_base, blk_new, dec_in, chain_cur;
   logic [4:0]   cnt;
   logic [3:0]   cnt_base;
   logic [7:0]   pad;
   always_comb begin
      blk_base  = req_data.first_byte ? 128'd0 : block_ff;
      cnt_base  = req_data.first_byte ? 4'd0 : count_ff;
      chain_cur = req_data.first_byte ? {iv_high_ff, iv_low_ff} : chain_ff;
      blk_new   = {blk_base[119:0], req_data.data_byte};
      cnt       = 5'(cnt_base) + 5'd1;
      pad       = 8'(5'd16 - cnt);
      dec_in    = blk_new << (8 * (5'd16 - cnt));
   end

   // decrypt padding check on the low bytes of the plain block
   logic [127:0] plain;
   logic [7:0]   p;
   logic         ok;
   always_comb begin
      plain = cipher_out ^ chain_ff;
      p = plain[7:0];
      ok = full_ff && p >= 8'd1 && p <= 8'd16;
      for (int i = 0; i < 16; i++) begin
         if (8'(i) < p && plain[8*i +: 8] != p) ok = 1'b0;
      end
   end

   // final encrypt block: message bytes moved up, pad bytes below
   logic [127:0] pad_fill;
   always_comb begin
      pad_fill = dec_in;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < 5'd16 - cnt) pad_fill[8*i +: 8] = pad;
      end
   end

   // output beat fields
   always_comb begin
      rsp_data.out_byte  = res_ff[127:120];
      rsp_data.out_last  = olast_ff && (emit_i_ff == emit_n_ff - 5'd1);
      rsp_data.pad_error = err_ff;
   end

   // state machine and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_KEXP;
         key_high_ff <= '0; key_low_ff <= '0; iv_high_ff <= '0; iv_low_ff <= '0;
         decrypt_ff <= 1'b0;
         chain_ff <= '0; block_ff <= '0; count_ff <= '0; res_ff <= '0;
         x_ff <= {scc_pkg::FK0, scc_pkg::FK1, scc_pkg::FK2, scc_pkg::FK3};
         rnd_ff <= '0; rsp_valid_ff <= 1'b0; primed_ff <= 1'b0;
         last_ff <= 1'b0; full_ff <= 1'b0; pend_pad_ff <= 1'b0;
         emit_n_ff <= '0; emit_i_ff <= '0; err_ff <= 1'b0; olast_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite) begin
            case (paddr)
               scc_pkg::ADDR_KEY_HIGH: key_high_ff <= pwdata;
               scc_pkg::ADDR_KEY_LOW:  key_low_ff <= pwdata;
               scc_pkg::ADDR_IV_HIGH:  iv_high_ff <= pwdata;
               scc_pkg::ADDR_IV_LOW:   iv_low_ff <= pwdata;
               scc_pkg::ADDR_DECRYPT:  decrypt_ff <= pwdata[0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_data.first_byte && !primed_ff) begin
                  // expand keys before the start beat is taken
                  x_ff <= {key_high_ff[63:32] ^ scc_pkg::FK0,
                     key_high_ff[31:0] ^ scc_pkg::FK1,
                     key_low_ff[63:32] ^ scc_pkg::FK2, key_low_ff[31:0] ^ scc_pkg::FK3};
                  rnd_ff <= '0;
                  primed_ff <= 1'b1;
                  state_ff <= S_KEXP;
               end else if (req_valid) begin
                  primed_ff <= 1'b0;
                  if (req_data.first_byte) chain_ff <= {iv_high_ff, iv_low_ff};
                  last_ff <= req_data.last_byte;
                  full_ff <= cnt[4];
                  pend_pad_ff <= 1'b0;
                  rnd_ff <= '0;
                  if (cnt[4] || req_data.last_byte) begin
                     count_ff <= '0;
                     state_ff <= S_CIPH;
                     if (decrypt_ff) begin
                        x_ff <= dec_in;
                        block_ff <= dec_in;
                     end else begin
                        block_ff <= '0;
                        x_ff <= (cnt[4] ? blk_new : pad_fill) ^ chain_cur;
                        pend_pad_ff <= cnt[4] && req_data.last_byte;
                     end
                  end else begin
                     count_ff <= cnt[3:0];
                     block_ff <= blk_new;
                  end
               end
            end
            S_KEXP: begin
               x_ff <= {x_ff[95:0], kround};
               rnd_ff <= rnd_ff + (RkW+1)'(1);
               if (rnd_ff == (RkW+1)'(RkDepth - 1)) begin
                  state_ff <= S_IDLE;
                  rnd_ff <= '0;
               end
            end
            S_CIPH: begin
               x_ff <= {x_ff[95:0], dround};
               rnd_ff <= rnd_ff + (RkW+1)'(1);
               if (rnd_ff == (RkW+1)'(RkDepth - 1)) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               // chain update and output block setup
               chain_ff <= decrypt_ff ? block_ff : cipher_out;
               block_ff <= '0;
               res_ff <= decrypt_ff ? plain : cipher_out;
               emit_i_ff <= '0;
               emit_n_ff <= 5'd16;
               err_ff <= 1'b0;
               olast_ff <= last_ff && !pend_pad_ff;
               if (decrypt_ff && last_ff) begin
                  if (ok) begin
                     emit_n_ff <= 5'd16 - 5'(p);
                  end else begin
                     err_ff <= 1'b1;
                  end
               end
               if (decrypt_ff && last_ff && ok && p == 8'd16) begin
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_OUT;
                  rsp_valid_ff <= 1'b1;
               end
            end
            S_OUT: begin
               if (rsp_ready) begin
                  res_ff <= {res_ff[119:0], 8'd0};
                  emit_i_ff <= emit_i_ff + 5'd1;
                  if (emit_i_ff == emit_n_ff - 5'd1) begin
                     rsp_valid_ff <= 1'b0;
                     if (pend_pad_ff) begin
                        // whole padding block after a full final block
                        x_ff <= {16{8'h10}} ^ chain_ff;
                        pend_pad_ff <= 1'b0;
                        rnd_ff <= '0;
                        state_ff <= S_CIPH;
                     end else begin
                        state_ff <= S_IDLE;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   `SCC_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE)
   `SCC_ASSERT_IMP(a_valid_out, clock, reset, rsp_valid, state_ff == S_OUT)
   `SCC_ASSERT_IMP(a_emit_range, clock, reset, state_ff == S_OUT, emit_i_ff < emit_n_ff)
   `SCC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))
   `SCC_ASSERT_NXT(a_kexp_done, clock, reset,
      state_ff == S_KEXP && rnd_ff == (RkW+1)'(RkDepth - 1), state_ff == S_IDLE)

endmodule
